/* rtl/aarm_pkg.sv */
// shared types, constants and tables for the axis-angle rotation matrix core
`default_nettype none
package aarm_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam logic signed [15:0] FULL_TURN = 16'sd23040;
    localparam logic signed [15:0] HALF_TURN = 16'sd11520;
    localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
    localparam logic signed [17:0] ENTRY_MAX = 18'sd65536;
    localparam int QUEUE_DEPTH = 2;

    // job handed from front end to back end
    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               zero;
    } job_t;

    function automatic logic signed [23:0] atan_entry(input logic [4:0] i);
        logic signed [23:0] r;
        begin
            case (i)
                5'd0: r = 24'sd2949120;
                5'd1: r = 24'sd1740967;
                5'd2: r = 24'sd919879;
                5'd3: r = 24'sd466945;
                5'd4: r = 24'sd234379;
                5'd5: r = 24'sd117304;
                5'd6: r = 24'sd58666;
                5'd7: r = 24'sd29335;
                5'd8: r = 24'sd14668;
                5'd9: r = 24'sd7334;
                5'd10: r = 24'sd3667;
                5'd11: r = 24'sd1833;
                5'd12: r = 24'sd917;
                5'd13: r = 24'sd458;
                5'd14: r = 24'sd229;
                5'd15: r = 24'sd115;
                5'd16: r = 24'sd57;
                5'd17: r = 24'sd29;
                5'd18: r = 24'sd14;
                5'd19: r = 24'sd7;
                default: r = 24'sd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/aarm_front.sv */
// front end: accepts beats, flags zero axes, holds a short job queue
`default_nettype none
module aarm_front (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  wire  [63:0]     s_data,
    output logic            job_valid,
    input  wire             job_take,
    output aarm_pkg::job_t  job
);
    import aarm_pkg::*;

    job_t q_reg [QUEUE_DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, wr_reg;
    job_t in_job;
    logic push, pop;

    assign in_job.angle = s_data[15:0];
    assign in_job.ax = s_data[31:16];
    assign in_job.ay = s_data[47:32];
    assign in_job.az = s_data[63:48];
    // axis zero exactly when all components are zero
    assign in_job.zero = (s_data[63:16] == 48'd0);

    assign s_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push = s_valid && s_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop = job_valid && job_take;
    assign job = q_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= in_job;
    end
endmodule
`default_nettype wire

/* rtl/aarm_back.sv */
// back end: cordic, square root, divides, products and entry emission
`default_nettype none
module aarm_back (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             job_valid,
    output logic            job_take,
    input  aarm_pkg::job_t  job,
    output logic            m_valid,
    input  wire             m_ready,
    output logic [23:0]     m_data,
    output logic            m_user,
    output logic            m_last
);
    import aarm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_CORDIC, S_SQRT, S_DIV, S_PROD, S_EMIT
    } state_t;

    state_t state_reg;
    logic [5:0] step_reg;
    job_t j_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [24:0] z_reg;
    logic neg_reg;
    // square root; the root is wide while it settles, final value fits 34 bits
    logic [65:0] rem_reg;
    logic [65:0] root_reg;
    logic [65:0] n_reg;
    // division: 62-bit dividend magnitude, 34-bit divisor
    logic [1:0] dsel_reg;
    logic [61:0] quo_reg;
    logic [33:0] drem_reg;
    logic signed [31:0] u_reg [3];
    // products
    logic signed [33:0] prod_a, prod_b;
    logic signed [67:0] prod;
    logic signed [33:0] pr_reg [12];
    logic [3:0] idx_reg;
    logic signed [33:0] acc;
    logic signed [20:0] ent;
    logic signed [17:0] val;
    logic sq_ge;
    logic [65:0] sq_bit;
    logic [65:0] sq_trial;
    logic [34:0] dtrial;
    logic signed [15:0] dsrc;
    logic signed [16:0] dwide;
    logic [15:0] dabs;
    logic signed [16:0] r0, r1;
    logic signed [33:0] dx, dy;
    logic signed [23:0] at;

    function automatic logic signed [33:0] rq30(input logic signed [67:0] p);
        logic signed [67:0] q;
        begin
            q = (p + 68'sd536870912) >>> 30;
            return q[33:0];
        end
    endfunction

    assign prod = prod_a * prod_b;
    assign job_take = (state_reg == S_IDLE) && job_valid;

    // angle fold: wrap into one turn, then to +-half turn, then to +-quarter turn
    always_comb begin
        r0 = 17'(job.angle);
        if (job.angle >= FULL_TURN) r0 = r0 - 17'(FULL_TURN);
        else if (job.angle < 0) begin
            r0 = r0 + 17'(FULL_TURN);
            if (r0 < 0) r0 = r0 + 17'(FULL_TURN);
        end
        if (r0 > 17'(HALF_TURN)) r0 = r0 - 17'(FULL_TURN);
        r1 = r0;
        if (r0 > 17'(QUARTER_TURN)) r1 = r0 - 17'(HALF_TURN);
        else if (r0 < -17'(QUARTER_TURN)) r1 = r0 + 17'(HALF_TURN);
    end

    // dividend magnitude of the component being divided
    always_comb begin
        case (dsel_reg)
            2'd0: dsrc = j_reg.ax;
            2'd1: dsrc = j_reg.ay;
            default: dsrc = j_reg.az;
        endcase
        dwide = 17'(dsrc);
        if (dwide < 0) dwide = -dwide;
        dabs = dwide[15:0];
    end

    assign dx = y_reg >>> step_reg[4:0];
    assign dy = x_reg >>> step_reg[4:0];
    assign at = atan_entry(step_reg[4:0]);
    assign sq_bit = 66'd1 << {step_reg, 1'b0};
    assign sq_trial = root_reg + sq_bit;
    assign sq_ge = rem_reg >= sq_trial;
    assign dtrial = {drem_reg, quo_reg[61]};

    // product schedule: step 0..2 t*u, 3..8 tx/ty/tz*u, 9..11 s*u
    always_comb begin
        prod_a = 34'sd0;
        prod_b = 34'sd0;
        case (step_reg[3:0])
            4'd0: begin prod_a = Q30_ONE - x_reg; prod_b = 34'(u_reg[0]); end
            4'd1: begin prod_a = Q30_ONE - x_reg; prod_b = 34'(u_reg[1]); end
            4'd2: begin prod_a = Q30_ONE - x_reg; prod_b = 34'(u_reg[2]); end
            4'd3: begin prod_a = pr_reg[0]; prod_b = 34'(u_reg[0]); end
            4'd4: begin prod_a = pr_reg[0]; prod_b = 34'(u_reg[1]); end
            4'd5: begin prod_a = pr_reg[0]; prod_b = 34'(u_reg[2]); end
            4'd6: begin prod_a = pr_reg[1]; prod_b = 34'(u_reg[1]); end
            4'd7: begin prod_a = pr_reg[1]; prod_b = 34'(u_reg[2]); end
            4'd8: begin prod_a = pr_reg[2]; prod_b = 34'(u_reg[2]); end
            4'd9: begin prod_a = y_reg; prod_b = 34'(u_reg[0]); end
            4'd10: begin prod_a = y_reg; prod_b = 34'(u_reg[1]); end
            4'd11: begin prod_a = y_reg; prod_b = 34'(u_reg[2]); end
            default: ;
        endcase
    end

    // entry select: pr 3 xx,4 xy,5 xz,6 yy,7 yz,8 zz,9 sx,10 sy,11 sz
    always_comb begin
        acc = 34'sd0;
        case (idx_reg)
            4'd0: acc = pr_reg[3] + x_reg;
            4'd1: acc = pr_reg[4] + pr_reg[11];
            4'd2: acc = pr_reg[5] - pr_reg[10];
            4'd4: acc = pr_reg[4] - pr_reg[11];
            4'd5: acc = pr_reg[6] + x_reg;
            4'd6: acc = pr_reg[7] + pr_reg[9];
            4'd8: acc = pr_reg[5] + pr_reg[10];
            4'd9: acc = pr_reg[7] - pr_reg[9];
            4'd10: acc = pr_reg[8] + x_reg;
            default: acc = 34'sd0;
        endcase
        ent = 21'((acc + 34'sd8192) >>> 14);
        if (ent > 21'(ENTRY_MAX)) val = ENTRY_MAX;
        else if (ent < -21'(ENTRY_MAX)) val = -ENTRY_MAX;
        else val = ent[17:0];
        if (idx_reg == 4'd15 || (j_reg.zero && (idx_reg == 4'd0 || idx_reg == 4'd5
                || idx_reg == 4'd10))) val = ENTRY_MAX;
        else if (j_reg.zero) val = 18'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid <= 1'b0;
            step_reg <= 6'd0;
            idx_reg <= 4'd0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        j_reg <= job;
                        x_reg <= CORDIC_GAIN;
                        y_reg <= 34'sd0;
                        z_reg <= 25'(r1) * 25'sd1024;
                        neg_reg <= (r0 != r1);
                        n_reg <= 66'(job.ax * job.ax) + 66'(job.ay * job.ay);
                        step_reg <= 6'd0;
                        state_reg <= job.zero ? S_EMIT : S_SETUP;
                        idx_reg <= 4'd0;
                    end
                end
                S_SETUP: begin
                    n_reg <= (n_reg + 66'(j_reg.az * j_reg.az)) << 32;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - dx; y_reg <= y_reg + dy;
                        z_reg <= z_reg - 25'(at);
                    end else begin
                        x_reg <= x_reg + dx; y_reg <= y_reg - dy;
                        z_reg <= z_reg + 25'(at);
                    end
                    if (step_reg == 6'(CORDIC_STEPS - 1)) begin
                        state_reg <= S_SQRT;
                        step_reg <= 6'd32;
                        rem_reg <= n_reg;
                        root_reg <= 66'd0;
                    end else step_reg <= step_reg + 6'd1;
                end
                S_SQRT: begin
                    if (step_reg == 6'd32) begin
                        x_reg <= neg_reg ? -x_reg : x_reg;
                        y_reg <= neg_reg ? -y_reg : y_reg;
                    end
                    if (sq_ge) begin
                        rem_reg <= rem_reg - sq_trial;
                        root_reg <= (root_reg >> 1) + sq_bit;
                    end else root_reg <= root_reg >> 1;
                    if (step_reg == 6'd0) begin
                        state_reg <= S_DIV;
                        dsel_reg <= 2'd0;
                    end else step_reg <= step_reg - 6'd1;
                end
                S_DIV: begin
                    if (step_reg == 6'd0) begin
                        quo_reg <= {dabs, 46'd0};
                        drem_reg <= 34'd0;
                        step_reg <= 6'd1;
                    end else begin
                        if (dtrial >= {1'b0, root_reg[33:0]}) begin
                            drem_reg <= 34'(dtrial - {1'b0, root_reg[33:0]});
                            quo_reg <= {quo_reg[60:0], 1'b1};
                        end else begin
                            drem_reg <= dtrial[33:0];
                            quo_reg <= {quo_reg[60:0], 1'b0};
                        end
                        if (step_reg == 6'd62) begin
                            step_reg <= 6'd0;
                            dsel_reg <= dsel_reg + 2'd1;
                            if (dsel_reg == 2'd2) state_reg <= S_PROD;
                        end else step_reg <= step_reg + 6'd1;
                    end
                end
                S_PROD: begin
                    pr_reg[step_reg[3:0]] <= rq30(prod);
                    if (step_reg == 6'd11) state_reg <= S_EMIT;
                    else step_reg <= step_reg + 6'd1;
                end
                S_EMIT: begin
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b1;
                        m_data <= {2'b00, val, idx_reg};
                        m_user <= j_reg.zero;
                        m_last <= (idx_reg == 4'd15);
                        idx_reg <= idx_reg + 4'd1;
                        if (idx_reg == 4'd15) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg != S_EMIT && m_valid && m_ready) m_valid <= 1'b0;
        end
    end

    // quotient sign applied after the last shift of each divide
    always_ff @(posedge aclk) begin
        if (state_reg == S_DIV && step_reg == 6'd0 && dsel_reg != 2'd0) begin
            case (dsel_reg)
                2'd1: u_reg[0] <= (j_reg.ax < 0) ? -32'(quo_reg) : 32'(quo_reg);
                2'd2: u_reg[1] <= (j_reg.ay < 0) ? -32'(quo_reg) : 32'(quo_reg);
                default: ;
            endcase
        end else if (state_reg == S_PROD && step_reg == 6'd0) begin
            u_reg[2] <= (j_reg.az < 0) ? -32'(quo_reg) : 32'(quo_reg);
        end
    end
endmodule
`default_nettype wire

/* rtl/axis_angle_rotation_matrix_core.sv */
// top level of the axis-angle rotation matrix core
//  channel | dir | payload
//  s_      | in  | angle_deg, axis_x, axis_y, axis_z
//  m_      | out | element_index, element_value, axis_zero, last_element
// an item with a nonzero axis runs: take, setup, 20 cordic steps, 33 root
// steps, 3x63 divide steps, 12 products, then 16 output beats
// zero axis skips straight to output
// aresetn synchronous active low; a two-deep queue lets input beats land while busy
// m_tvalid holds across stalls; a stalled output freezes the back end while it emits entries
`default_nettype none
module axis_angle_rotation_matrix_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,  // angle_deg, axis_x, axis_y, axis_z
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,  // element_index, element_value, pad
    output logic        m_tuser,  // axis_zero
    output logic        m_tlast   // last_element
);
    import aarm_pkg::*;

    job_t job;
    logic job_valid, job_take;

    aarm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_tvalid), .s_ready(s_tready),
        .s_data(s_tdata), .job_valid(job_valid), .job_take(job_take), .job(job)
    );

    aarm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(job_valid), .job_take(job_take),
        .job(job), .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata),
        .m_user(m_tuser), .m_last(m_tlast)
    );

`ifndef SYNTHESIS
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'd15)))
        else $error("tlast mismatch");
    a_one_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:0] == 4'd15) |-> (m_tdata[21:4] == 18'd65536))
        else $error("entry 15 not one");
`endif
endmodule
`default_nettype wire
